>>> hw/rtl/skyp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// skyp_pkg
// Types and constants shared by the skyline packer cells and the top level.
// ----------------------------------------------------------------------------
package skyp_pkg;

	localparam int unsigned VW = 13;

	localparam logic [VW-1:0] RESET_DIM = 13'd1024;

	localparam logic FUNC_ALLOC = 1'b0;
	localparam logic FUNC_CLEAR = 1'b1;

	localparam logic CFG_ATLAS_W = 1'b0;
	localparam logic CFG_ATLAS_H = 1'b1;

	localparam logic [1:0] ST_PLACED  = 2'd0;
	localparam logic [1:0] ST_NOSPACE = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;
	localparam logic [1:0] ST_CLEARED = 2'd3;

	typedef struct packed {
		logic          func;
		logic [VW-1:0] req_width;
		logic [VW-1:0] req_height;
	} in_word_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [11:0] offset_x;
		logic [11:0] offset_y;
	} out_word_t;

	typedef struct packed {
		logic          v;
		logic [VW-1:0] x;
		logic [VW-1:0] top;
		logic [VW-1:0] w;
	} seg_t;

	typedef struct packed {
		logic          run;
		logic          ok;
		logic [VW-1:0] y;
		logic [VW:0]   cov;
		logic [VW-1:0] x;
		logic [VW-1:0] sw;
	} cand_t;

	typedef enum logic [3:0] {
		CMD_IDLE,
		CMD_CLEAR,
		CMD_LOAD,
		CMD_EVAL,
		CMD_SCAN,
		CMD_INSERT,
		CMD_TRIM,
		CMD_COMPACT,
		CMD_ABSORB
	} cell_cmd_t;

	typedef struct packed {
		cell_cmd_t     cmd;
		logic [VW-1:0] req_w;
		logic [VW-1:0] req_h;
		logic [VW-1:0] atlas_w;
		logic [VW-1:0] atlas_h;
		seg_t          new_seg;
		logic [VW:0]   trim_end;
	} cell_ctl_t;

endpackage
`default_nettype wire

>>> hw/rtl/skyp_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// skyp_cell
// One skyline segment slot with its shadow copy and its fit candidate.
// ----------------------------------------------------------------------------
module skyp_cell #(
	parameter int unsigned IW  = 6,
	parameter int unsigned IDX = 0
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire skyp_pkg::cell_ctl_t     ctl,
	input  wire [IW-1:0]                 best,
	input  wire skyp_pkg::seg_t          left_seg,
	input  wire                          left_del,
	input  wire                          left_absorb,
	input  wire skyp_pkg::seg_t          right_seg,
	input  wire skyp_pkg::seg_t          right_sh,
	input  wire skyp_pkg::cand_t         right_cand,
	input  wire                          right_del,
	output skyp_pkg::seg_t               seg,
	output skyp_pkg::seg_t               sh,
	output skyp_pkg::cand_t              cand,
	output logic                         del,
	output logic                         absorb,
	output logic                         eq_r
);

	localparam int unsigned VW = skyp_pkg::VW;

	skyp_pkg::seg_t  seg_q, sh_q;
	skyp_pkg::cand_t cand_q;
	logic            del_q;

	logic          after_best, at_best, eq_l;
	logic [VW-1:0] ny;
	logic [VW:0]   ny_top, ncov, seg_end, start_end;

	assign at_best    = (best == IW'(IDX));
	assign after_best = (IW'(IDX) > best);
	assign eq_l  = left_seg.v && seg_q.v && (left_seg.top == seg_q.top);
	assign eq_r  = right_seg.v && seg_q.v && (right_seg.top == seg_q.top);
	assign absorb = eq_r && !eq_l;

	always_comb begin
		ny        = (sh_q.top > cand_q.y) ? sh_q.top : cand_q.y;
		ny_top    = {1'b0, ny} + {1'b0, ctl.req_h};
		ncov      = cand_q.cov + {1'b0, sh_q.w};
		seg_end   = {1'b0, seg_q.x} + {1'b0, seg_q.w};
		start_end = {1'b0, seg_q.x} + {1'b0, ctl.req_w};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_q  <= '{v: 1'(IDX == 0), x: '0, top: '0,
				w: (IDX == 0) ? skyp_pkg::RESET_DIM : '0};
			sh_q   <= '0;
			cand_q <= '0;
			del_q  <= 1'b0;
		end else begin
			unique case (ctl.cmd)
				skyp_pkg::CMD_CLEAR: begin
					seg_q <= '{v: 1'(IDX == 0), x: '0, top: '0, w: ctl.atlas_w};
					del_q <= 1'b0;
				end
				skyp_pkg::CMD_LOAD: begin
					sh_q   <= seg_q;
					cand_q <= '{run: seg_q.v && (start_end <= {1'b0, ctl.atlas_w}),
						ok: 1'b0, y: '0, cov: '0, x: seg_q.x, sw: seg_q.w};
				end
				skyp_pkg::CMD_EVAL: begin
					// shadow line moves one slot down, so step k sees segment idx+k
					sh_q <= right_sh;
					if (cand_q.run) begin
						if (!sh_q.v || (ny_top > {1'b0, ctl.atlas_h})) begin
							cand_q.run <= 1'b0;
						end else begin
							cand_q.y   <= ny;
							cand_q.cov <= ncov;
							if (ncov >= {1'b0, ctl.req_w}) begin
								cand_q.run <= 1'b0;
								cand_q.ok  <= 1'b1;
							end
						end
					end
				end
				skyp_pkg::CMD_SCAN: begin
					cand_q <= right_cand;
				end
				skyp_pkg::CMD_INSERT: begin
					if (at_best) begin
						seg_q <= ctl.new_seg;
					end else if (after_best) begin
						seg_q <= left_seg;
					end
				end
				skyp_pkg::CMD_TRIM: begin
					if (after_best && seg_q.v && ({1'b0, seg_q.x} < ctl.trim_end)) begin
						if (seg_end <= ctl.trim_end) begin
							del_q <= 1'b1;
						end else begin
							seg_q.x <= ctl.trim_end[VW-1:0];
							seg_q.w <= VW'(seg_end - ctl.trim_end);
						end
					end
				end
				skyp_pkg::CMD_COMPACT: begin
					// holes bubble towards the end and vanish there
					if (del_q && !right_del) begin
						if (right_seg.v) begin
							seg_q <= right_seg;
						end else begin
							seg_q.v <= 1'b0;
						end
						del_q <= 1'b0;
					end else if (left_del && !del_q && seg_q.v) begin
						del_q <= 1'b1;
					end
				end
				skyp_pkg::CMD_ABSORB: begin
					if (absorb) begin
						seg_q.w <= seg_q.w + right_seg.w;
					end else if (left_absorb) begin
						del_q <= 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign seg  = seg_q;
	assign sh   = sh_q;
	assign cand = cand_q;
	assign del  = del_q;

endmodule
`default_nettype wire

>>> hw/rtl/skyline_rectangle_packer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// skyline_rectangle_packer
// Skyline bottom-left rectangle allocator built as a row of segment cells.
// ----------------------------------------------------------------------------
// Input words arrive on in_valid/in_stall/in_data: func selects allocate or
// clear, req_width/req_height give the rectangle. Each word yields one
// output word on out_valid/out_stall/out_data with a status and offsets.
// atlas_width and atlas_height are written through cfg_we/cfg_index/cfg_data;
// the user writes them only while the block is idle, which the block itself does not enforce; both reset to 1024.
// One word is worked on at a time. A clear, a full list or a zero width
// goes straight to the done state and from there to the output register.
// An allocate runs a load step, the fit tests (the shadow line walking
// through the cells), a candidate scan at cell 0 over every slot, then
// insert and trim, then a merge phase: each removed segment leaves a hole
// that walks one cell per cycle to the end of the row, with one round for
// the trim and one for each merge with a neighbour.
// Reset leaves one full-width segment at height zero. A stalled result sits
// in the output register; the next word is accepted once the previous one
// has its result registered, and waits in its last state if out_stall holds.
// ----------------------------------------------------------------------------
module skyline_rectangle_packer #(
	parameter int unsigned MAX_SEGMENTS = 64
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       in_valid,
	output logic                      in_stall,
	input  wire skyp_pkg::in_word_t   in_data,
	output logic                      out_valid,
	input  wire                       out_stall,
	output skyp_pkg::out_word_t       out_data,
	input  wire                       cfg_we,
	input  wire                       cfg_index,
	input  wire [skyp_pkg::VW-1:0]    cfg_data
);

	localparam int unsigned VW = skyp_pkg::VW;
	localparam int unsigned IW = $clog2(MAX_SEGMENTS);

	typedef enum logic [7:0] {
		S_IDLE   = 8'b0000_0001,
		S_LOAD   = 8'b0000_0010,
		S_EVAL   = 8'b0000_0100,
		S_SCAN   = 8'b0000_1000,
		S_INSERT = 8'b0001_0000,
		S_TRIM   = 8'b0010_0000,
		S_MERGE  = 8'b0100_0000,
		S_DONE   = 8'b1000_0000
	} state_t;

	state_t              state_q;
	logic [VW-1:0]       atlas_w_q, atlas_h_q, req_w_q, req_h_q;
	logic [VW-1:0]       bw_q, bx_q, by_q;
	logic [VW:0]         bt_q;
	logic [IW-1:0]       cnt_q, best_q;
	logic                found_q, out_valid_q;
	skyp_pkg::out_word_t res_q, out_q;

	skyp_pkg::cell_ctl_t ctl;
	skyp_pkg::seg_t      seg_a [MAX_SEGMENTS];
	skyp_pkg::seg_t      sh_a  [MAX_SEGMENTS];
	skyp_pkg::cand_t     cand_a[MAX_SEGMENTS];
	logic [MAX_SEGMENTS-1:0] del_v, absorb_v, eq_v, run_v;

	logic        any_del, any_eq, any_run, accept, upd, list_full, out_load;
	logic [VW:0] t_cur;

	genvar g;
	generate
		for (g = 0; g < MAX_SEGMENTS; g++) begin : g_cell
			skyp_pkg::seg_t  l_seg, r_seg, r_sh;
			skyp_pkg::cand_t r_cand;
			logic            l_del, l_abs, r_del;
			if (g == 0) begin : g_first
				assign l_seg = '0;
				assign l_del = 1'b0;
				assign l_abs = 1'b0;
			end else begin : g_mid_l
				assign l_seg = seg_a[g-1];
				assign l_del = del_v[g-1];
				assign l_abs = absorb_v[g-1];
			end
			if (g == MAX_SEGMENTS - 1) begin : g_last
				assign r_seg  = '0;
				assign r_sh   = '0;
				assign r_cand = '0;
				assign r_del  = 1'b0;
			end else begin : g_mid_r
				assign r_seg  = seg_a[g+1];
				assign r_sh   = sh_a[g+1];
				assign r_cand = cand_a[g+1];
				assign r_del  = del_v[g+1];
			end
			skyp_cell #(.IW(IW), .IDX(g)) u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.ctl        (ctl),
				.best       (best_q),
				.left_seg   (l_seg),
				.left_del   (l_del),
				.left_absorb(l_abs),
				.right_seg  (r_seg),
				.right_sh   (r_sh),
				.right_cand (r_cand),
				.right_del  (r_del),
				.seg        (seg_a[g]),
				.sh         (sh_a[g]),
				.cand       (cand_a[g]),
				.del        (del_v[g]),
				.absorb     (absorb_v[g]),
				.eq_r       (eq_v[g])
			);
			assign run_v[g] = cand_a[g].run;
		end
	endgenerate

	assign any_del   = |del_v;
	assign any_eq    = |eq_v;
	assign any_run   = |run_v;
	assign list_full = seg_a[MAX_SEGMENTS-1].v;
	assign accept    = in_valid && !in_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign out_load  = (state_q == S_DONE) && (!out_valid_q || !out_stall);

	// candidate at the head of the row during the scan
	assign t_cur = {1'b0, cand_a[0].y} + {1'b0, req_h_q};
	assign upd   = cand_a[0].ok &&
		(!found_q || (t_cur < bt_q) || ((t_cur == bt_q) && (cand_a[0].sw < bw_q)));

	always_comb begin
		ctl.req_w    = req_w_q;
		ctl.req_h    = req_h_q;
		ctl.atlas_w  = atlas_w_q;
		ctl.atlas_h  = atlas_h_q;
		ctl.new_seg  = '{v: 1'b1, x: bx_q, top: by_q + req_h_q, w: req_w_q};
		ctl.trim_end = {1'b0, bx_q} + {1'b0, req_w_q};
		ctl.cmd      = skyp_pkg::CMD_IDLE;
		unique case (state_q)
			S_IDLE: begin
				if (accept && (in_data.func == skyp_pkg::FUNC_CLEAR)) begin
					ctl.cmd = skyp_pkg::CMD_CLEAR;
				end
			end
			S_LOAD:   ctl.cmd = skyp_pkg::CMD_LOAD;
			S_EVAL:   ctl.cmd = skyp_pkg::CMD_EVAL;
			S_SCAN:   ctl.cmd = skyp_pkg::CMD_SCAN;
			S_INSERT: ctl.cmd = skyp_pkg::CMD_INSERT;
			S_TRIM:   ctl.cmd = skyp_pkg::CMD_TRIM;
			S_MERGE: begin
				if (any_del) begin
					ctl.cmd = skyp_pkg::CMD_COMPACT;
				end else if (any_eq) begin
					ctl.cmd = skyp_pkg::CMD_ABSORB;
				end
			end
			S_DONE:   ctl.cmd = skyp_pkg::CMD_IDLE;
			default:  ctl.cmd = skyp_pkg::CMD_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			atlas_w_q <= skyp_pkg::RESET_DIM;
			atlas_h_q <= skyp_pkg::RESET_DIM;
		end else if (cfg_we) begin
			unique case (cfg_index)
				skyp_pkg::CFG_ATLAS_W: atlas_w_q <= cfg_data;
				skyp_pkg::CFG_ATLAS_H: atlas_h_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else if (out_load) begin
			out_q       <= res_q;
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			found_q <= 1'b0;
			cnt_q   <= '0;
			best_q  <= '0;
			req_w_q <= '0;
			req_h_q <= '0;
			res_q   <= '0;
			bt_q    <= '0;
			bw_q    <= '0;
			bx_q    <= '0;
			by_q    <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						req_w_q <= in_data.req_width;
						req_h_q <= in_data.req_height;
						found_q <= 1'b0;
						cnt_q   <= '0;
						priority if (in_data.func == skyp_pkg::FUNC_CLEAR) begin
							res_q   <= '{status: skyp_pkg::ST_CLEARED,
								offset_x: '0, offset_y: '0};
							state_q <= S_DONE;
						end else if (list_full) begin
							res_q   <= '{status: skyp_pkg::ST_FULL,
								offset_x: '0, offset_y: '0};
							state_q <= S_DONE;
						end else if (in_data.req_width == '0) begin
							res_q   <= '{status: skyp_pkg::ST_NOSPACE,
								offset_x: '0, offset_y: '0};
							state_q <= S_DONE;
						end else begin
							res_q   <= '0;
							state_q <= S_LOAD;
						end
					end
				end
				S_LOAD: state_q <= S_EVAL;
				S_EVAL: begin
					if (!any_run) begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (upd) begin
						found_q <= 1'b1;
						bt_q    <= t_cur;
						bw_q    <= cand_a[0].sw;
						bx_q    <= cand_a[0].x;
						by_q    <= cand_a[0].y;
						best_q  <= cnt_q;
					end
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == IW'(MAX_SEGMENTS - 1)) begin
						if (found_q || upd) begin
							res_q.status <= skyp_pkg::ST_PLACED;
							res_q.offset_x <= upd ? cand_a[0].x[11:0] : bx_q[11:0];
							res_q.offset_y <= upd ? cand_a[0].y[11:0] : by_q[11:0];
							state_q <= S_INSERT;
						end else begin
							res_q.status <= skyp_pkg::ST_NOSPACE;
							state_q      <= S_DONE;
						end
					end
				end
				S_INSERT: state_q <= S_TRIM;
				S_TRIM:   state_q <= S_MERGE;
				S_MERGE: begin
					if (!any_del && !any_eq) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// a taken word always starts work
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> in_stall)
		else $error("packer idle after accepting a word");

	// the first slot always holds a segment
	a_head_valid: assert property (@(posedge clk) disable iff (!arst_n)
		seg_a[0].v)
		else $error("skyline lost its first segment");

	// no hole is left behind once a word is finished
	a_no_hole_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !any_del)
		else $error("hole left in segment row while idle");

endmodule
`default_nettype wire

>>> sim/skyline_rectangle_packer_test.sv
// ----------------------------------------------------------------------------
// skyline_rectangle_packer_test
// Self-checking bench for the skyline packer. Each accepted request goes
// through a behavioural skyline model that predicts status and offsets. The
// bench covers directed corner cases, a staircase fill that runs the segment
// list full, and random traffic under several atlas sizes, with random gaps
// on the input channel and random stalls on the output channel.
// ----------------------------------------------------------------------------
module skyline_rectangle_packer_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned NSEG = 64;
	localparam int unsigned CYCLE_LIMIT = 5000000;
	localparam int unsigned VW = skyp_pkg::VW;

	class placement_board;
		int unsigned aw, ah;
		int unsigned sx[NSEG+1];
		int unsigned st[NSEG+1];
		int unsigned sw[NSEG+1];
		int unsigned cnt;
		skyp_pkg::out_word_t placements[$];
		int errors;

		function void reset_state();
			aw = 1024;
			ah = 1024;
			flatten();
			errors = 0;
		endfunction

		function void flatten();
			foreach (sx[i]) begin
				sx[i] = 0;
				st[i] = 0;
				sw[i] = 0;
			end
			sw[0] = aw & 13'h1fff;
			cnt = 1;
		endfunction

		function void write_reg(logic idx, logic [VW-1:0] val);
			if (idx == skyp_pkg::CFG_ATLAS_W) aw = val;
			else ah = val;
		endfunction

		function int fit_base(int unsigned s, int unsigned w, int unsigned h);
			int unsigned covered, y, i;
			covered = 0;
			y = st[s];
			i = s;
			if (sx[s] + w > aw) return -1;
			while (covered < w) begin
				if (i >= cnt) return -1;
				if (st[i] > y) y = st[i];
				if (y + h > ah) return -1;
				covered += sw[i];
				i++;
			end
			return int'(y);
		endfunction

		function void drop(int unsigned j);
			for (int unsigned k = j; k + 1 < cnt; k++) begin
				sx[k] = sx[k+1];
				st[k] = st[k+1];
				sw[k] = sw[k+1];
			end
			cnt--;
		endfunction

		function void note(skyp_pkg::in_word_t wd);
			skyp_pkg::out_word_t o;
			int unsigned w, h, best, btop, bw, bx, by, t, fin, j, shrink;
			int y;
			bit found;
			w = wd.req_width;
			h = wd.req_height;
			o = '0;
			found = 0;
			best = 0;
			btop = 32'hffffffff;
			bw = 32'hffffffff;
			bx = 0;
			by = 0;
			if (wd.func == skyp_pkg::FUNC_CLEAR) begin
				flatten();
				o.status = skyp_pkg::ST_CLEARED;
			end else if (cnt >= NSEG) begin
				o.status = skyp_pkg::ST_FULL;
			end else if (w == 0) begin
				o.status = skyp_pkg::ST_NOSPACE;
			end else begin
				for (int unsigned i = 0; i < cnt; i++) begin
					y = fit_base(i, w, h);
					if (y >= 0) begin
						t = int'(y) + h;
						if (t < btop || (t == btop && sw[i] < bw)) begin
							btop = t;
							bw = sw[i];
							best = i;
							bx = sx[i];
							by = y;
							found = 1;
						end
					end
				end
				if (!found) begin
					o.status = skyp_pkg::ST_NOSPACE;
				end else begin
					for (int unsigned i = cnt; i > best; i--) begin
						sx[i] = sx[i-1];
						st[i] = st[i-1];
						sw[i] = sw[i-1];
					end
					sx[best] = bx & 13'h1fff;
					st[best] = (by + h) & 13'h1fff;
					sw[best] = w;
					cnt++;
					fin = sx[best] + sw[best];
					while (best + 1 < cnt) begin
						j = best + 1;
						if (sx[j] >= fin) break;
						shrink = fin - sx[j];
						if (sw[j] <= shrink) begin
							drop(j);
						end else begin
							sx[j] = (sx[j] + shrink) & 13'h1fff;
							sw[j] -= shrink;
							break;
						end
					end
					j = 0;
					while (j + 1 < cnt) begin
						if (st[j] == st[j+1]) begin
							sw[j] = (sw[j] + sw[j+1]) & 13'h1fff;
							drop(j + 1);
						end else begin
							j++;
						end
					end
					o.status = skyp_pkg::ST_PLACED;
					o.offset_x = bx[11:0];
					o.offset_y = by[11:0];
				end
			end
			placements.insert(placements.size(), o);
		endfunction

		function void check(skyp_pkg::out_word_t got);
			skyp_pkg::out_word_t e;
			if (placements.size() == 0) begin
				$display("%0t: unexpected word status=%0d x=%0d y=%0d", $realtime,
					got.status, got.offset_x, got.offset_y);
				errors++;
				return;
			end
			e = placements.pop_front();
			if (got.status !== e.status) begin
				$display("%0t: status expected %0d actual %0d", $realtime, e.status, got.status);
				errors++;
			end
			if (got.offset_x !== e.offset_x) begin
				$display("%0t: offset_x expected %0d actual %0d", $realtime,
					e.offset_x, got.offset_x);
				errors++;
			end
			if (got.offset_y !== e.offset_y) begin
				$display("%0t: offset_y expected %0d actual %0d", $realtime,
					e.offset_y, got.offset_y);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	skyp_pkg::in_word_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	skyp_pkg::out_word_t out_data;
	logic cfg_we = 1'b0;
	logic cfg_index = 1'b0;
	logic [VW-1:0] cfg_data = '0;

	placement_board board;
	int unsigned cycles = 0;
	int unsigned stall_burst = 0;
	bit running = 0;

	skyline_rectangle_packer #(.MAX_SEGMENTS(NSEG)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		forever begin
			#1 clk = ~clk;
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// result side: sample with pre-edge values, then pick the next stall
	initial begin
		forever begin
			@(posedge clk);
			if (running && out_valid && !out_stall) board.check(out_data);
			if (!running) begin
				out_stall <= 1'b0;
			end else if (stall_burst > 0) begin
				stall_burst--;
				out_stall <= 1'b1;
			end else if ($urandom_range(0, 99) < 2) begin
				stall_burst = $urandom_range(20, 300);
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(0, 99) < 25);
			end
		end
	end

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 200);
	endfunction

	task automatic send(logic f, int unsigned w, int unsigned h);
		int unsigned gap;
		skyp_pkg::in_word_t wd;
		gap = pick_gap();
		wd.func = f;
		wd.req_width = w[VW-1:0];
		wd.req_height = h[VW-1:0];
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= wd;
		do @(posedge clk); while (in_stall);
		board.note(wd);
	endtask

	// hold off until every word is back, then let the block settle
	task automatic drain();
		in_valid <= 1'b0;
		while (board.placements.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, int unsigned val);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[VW-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		board.write_reg(idx, val[VW-1:0]);
	endtask

	task automatic random_words(int unsigned n);
		int unsigned r, aw, ah;
		for (int unsigned k = 0; k < n; k++) begin
			aw = board.aw;
			ah = board.ah;
			r = $urandom_range(0, 99);
			if (r < 4) send(skyp_pkg::FUNC_CLEAR, $urandom_range(0, 8191),
				$urandom_range(0, 8191));
			else if (r < 6) send(skyp_pkg::FUNC_ALLOC, 0, $urandom_range(0, 8191));
			else if (r < 12) send(skyp_pkg::FUNC_ALLOC, $urandom_range(0, 8191),
				$urandom_range(0, 8191));
			else send(skyp_pkg::FUNC_ALLOC, $urandom_range(1, aw / 6 + 1),
				$urandom_range(0, ah / 10 + 1));
		end
	endtask

	initial begin
		board = new();
		board.reset_state();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		running = 1;
		@(posedge clk);

		// directed corners at reset size
		send(skyp_pkg::FUNC_ALLOC, 0, 5);
		send(skyp_pkg::FUNC_ALLOC, 4096, 4096);
		send(skyp_pkg::FUNC_ALLOC, 1024, 0);
		send(skyp_pkg::FUNC_ALLOC, 1024, 1024);
		send(skyp_pkg::FUNC_ALLOC, 1, 1);
		send(skyp_pkg::FUNC_CLEAR, 8191, 8191);
		send(skyp_pkg::FUNC_ALLOC, 1, 1);
		send(skyp_pkg::FUNC_ALLOC, 1023, 1);
		send(skyp_pkg::FUNC_ALLOC, 8191, 1);
		send(skyp_pkg::FUNC_ALLOC, 512, 8191);
		send(skyp_pkg::FUNC_ALLOC, 512, 1023);
		send(skyp_pkg::FUNC_ALLOC, 300, 2);
		send(skyp_pkg::FUNC_ALLOC, 300, 2);
		send(skyp_pkg::FUNC_ALLOC, 1024, 1);
		send(skyp_pkg::FUNC_CLEAR, 0, 0);
		// staircase: distinct tops never merge, so the list runs full
		for (int unsigned k = 1; k <= 68; k++) send(skyp_pkg::FUNC_ALLOC, 1, k);
		send(skyp_pkg::FUNC_CLEAR, 0, 0);
		random_words(60);

		write_reg(skyp_pkg::CFG_ATLAS_W, 1);
		write_reg(skyp_pkg::CFG_ATLAS_H, 1);
		send(skyp_pkg::FUNC_CLEAR, 0, 0);
		send(skyp_pkg::FUNC_ALLOC, 1, 1);
		send(skyp_pkg::FUNC_ALLOC, 1, 0);
		send(skyp_pkg::FUNC_ALLOC, 2, 0);
		random_words(40);

		write_reg(skyp_pkg::CFG_ATLAS_W, 4096);
		write_reg(skyp_pkg::CFG_ATLAS_H, 4096);
		send(skyp_pkg::FUNC_CLEAR, 0, 0);
		send(skyp_pkg::FUNC_ALLOC, 4096, 4096);
		send(skyp_pkg::FUNC_ALLOC, 1, 0);
		send(skyp_pkg::FUNC_CLEAR, 0, 0);
		random_words(60);

		write_reg(skyp_pkg::CFG_ATLAS_W, 64);
		write_reg(skyp_pkg::CFG_ATLAS_H, 4096);
		send(skyp_pkg::FUNC_CLEAR, 0, 0);
		for (int unsigned r = 0; r < 4; r++) begin
			for (int unsigned k = 1; k <= 66; k++)
				send(skyp_pkg::FUNC_ALLOC, 1, $urandom_range(1, 60));
			send(skyp_pkg::FUNC_CLEAR, 0, 0);
		end
		random_words(60);

		write_reg(skyp_pkg::CFG_ATLAS_W, 4096);
		write_reg(skyp_pkg::CFG_ATLAS_H, 64);
		send(skyp_pkg::FUNC_CLEAR, 0, 0);
		random_words(60);

		// width grows without a clear: the skyline is shorter than the atlas
		write_reg(skyp_pkg::CFG_ATLAS_W, 300);
		write_reg(skyp_pkg::CFG_ATLAS_H, 1024);
		send(skyp_pkg::FUNC_CLEAR, 0, 0);
		send(skyp_pkg::FUNC_ALLOC, 100, 10);
		write_reg(skyp_pkg::CFG_ATLAS_W, 1000);
		send(skyp_pkg::FUNC_ALLOC, 250, 5);
		send(skyp_pkg::FUNC_ALLOC, 600, 5);
		send(skyp_pkg::FUNC_ALLOC, 350, 1);
		random_words(60);

		write_reg(skyp_pkg::CFG_ATLAS_W, 1024);
		write_reg(skyp_pkg::CFG_ATLAS_H, 1024);
		send(skyp_pkg::FUNC_CLEAR, 0, 0);
		random_words(60);

		drain();
		repeat (300) @(posedge clk);
		if (board.errors == 0 && board.placements.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end
endmodule

>>> files.f
hw/rtl/skyp_pkg.sv
hw/rtl/skyp_cell.sv
hw/rtl/skyline_rectangle_packer.sv
sim/skyline_rectangle_packer_test.sv
